@@ rtl/v3n_pkg.sv @@
// Shared types for the 3D vector normalization unit.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none
package v3n_pkg;
	// component sign bits travelling alongside the datapath
	typedef struct packed {
		logic x;
		logic y;
		logic z;
	} sign_t;
endpackage
`default_nettype wire

@@ rtl/v3n_if.sv @@
// Valid/ready channel interfaces for vector requests and normalized results.
// Depends on v3n_pkg.
`default_nettype none
interface v3n_req_if import v3n_pkg::*; #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] x_in;
	logic signed [W-1:0] y_in;
	logic signed [W-1:0] z_in;
	modport source (output valid, x_in, y_in, z_in, input ready);
	modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface v3n_res_if import v3n_pkg::*; #(parameter int W = 32, parameter int F = 30);
	logic                valid;
	logic                ready;
	logic signed [F+1:0] x_unit;
	logic signed [F+1:0] y_unit;
	logic signed [F+1:0] z_unit;
	logic        [W-1:0] magnitude;
	logic                is_zero;
	modport source (output valid, x_unit, y_unit, z_unit, magnitude, is_zero, input ready);
	modport sink   (input valid, x_unit, y_unit, z_unit, magnitude, is_zero, output ready);
endinterface
`default_nettype wire

@@ rtl/vec3_normalize_unit.sv @@
// Top level of the 3D vector normalization unit: pipelined length and divide.
// Depends on v3n_pkg and the channel interfaces in v3n_if.sv.
`default_nettype none
// vec3_normalize_unit takes one vector per cycle (signed fixed point, IN_WIDTH
// bits per component) and returns its floor-sqrt length and each component
// divided by that length as signed Q1.OUT_FRAC, truncated toward zero. The
// zero vector returns all zeros with is_zero set. Throughput is one vector
// per clock while the sink keeps up; the pipeline core is the square
// root (one result bit per stage, IN_WIDTH+1 stages) followed by three
// parallel restoring dividers (one quotient bit per stage, OUT_FRAC+1 stages).
// The whole pipeline advances together: it holds while the last stage has a
// result that the sink has not taken, so no request is lost or repeated.
module vec3_normalize_unit
	import v3n_pkg::*;
#(
	parameter int IN_WIDTH = 32,
	parameter int OUT_FRAC = 30
) (
	input  wire logic clk,
	input  wire logic arst_n,
	v3n_req_if.sink   req,
	v3n_res_if.source res
);
	localparam int W   = IN_WIDTH;
	localparam int F   = OUT_FRAC;
	localparam int RW  = W + 1;          // root width
	localparam int SW  = 2 * RW;         // padded sum width
	localparam int RMW = RW + 4;         // root remainder width
	localparam int DW  = RW + 1;         // divider remainder width
	localparam int SQ0 = 3;              // first root stage index
	localparam int DV0 = SQ0 + RW;       // first divide stage index
	localparam int L   = DV0 + F + 1;    // stages in total

	logic adv;
	logic vld_s [0:L-1];

	// advance whenever the last stage is empty or being taken
	assign adv       = !vld_s[L-1] || res.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= req.valid;
			for (int i = 1; i < L; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: magnitudes and signs
	logic [W-1:0] ax_s1, ay_s1, az_s1;
	sign_t        sg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sg_s1 <= '{x: req.x_in[W-1], y: req.y_in[W-1], z: req.z_in[W-1]};
			ax_s1 <= req.x_in[W-1] ? W'(-req.x_in) : W'(req.x_in);
			ay_s1 <= req.y_in[W-1] ? W'(-req.y_in) : W'(req.y_in);
			az_s1 <= req.z_in[W-1] ? W'(-req.z_in) : W'(req.z_in);
		end
	end

	// stage 2: exact squares
	logic [2*W-1:0] qx_s2, qy_s2, qz_s2;
	logic [W-1:0]   ax_s2, ay_s2, az_s2;
	sign_t          sg_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s2 <= ax_s1 * ax_s1;
			qy_s2 <= ay_s1 * ay_s1;
			qz_s2 <= az_s1 * az_s1;
			ax_s2 <= ax_s1; ay_s2 <= ay_s1; az_s2 <= az_s1;
			sg_s2 <= sg_s1;
		end
	end

	// stage 3: sum of squares, padded to the root's bit pairs
	logic [SW-1:0] sum_s3;
	logic [W-1:0]  ax_s3, ay_s3, az_s3;
	sign_t         sg_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= SW'(qx_s2) + SW'(qy_s2) + SW'(qz_s2);
			ax_s3 <= ax_s2; ay_s3 <= ay_s2; az_s3 <= az_s2;
			sg_s3 <= sg_s2;
		end
	end

	// square root: one root bit per stage, two sum bits consumed each
	logic [SW-1:0]  rs_s [0:RW];
	logic [RMW-1:0] rr_s [0:RW];
	logic [RW-1:0]  rt_s [0:RW];
	logic [W-1:0]   rx_s [0:RW], ry_s [0:RW], rz_s [0:RW];
	sign_t          rg_s [0:RW];

	assign rs_s[0] = sum_s3;
	assign rr_s[0] = '0;
	assign rt_s[0] = '0;
	assign rx_s[0] = ax_s3;
	assign ry_s[0] = ay_s3;
	assign rz_s[0] = az_s3;
	assign rg_s[0] = sg_s3;

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [RMW-1:0] pre, trial;
		assign pre   = {rr_s[k][RMW-3:0], rs_s[k][SW-1 -: 2]};
		assign trial = {2'b00, rt_s[k], 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				rs_s[k+1] <= {rs_s[k][SW-3:0], 2'b00};
				if (pre >= trial) begin
					rr_s[k+1] <= pre - trial;
					rt_s[k+1] <= {rt_s[k][RW-2:0], 1'b1};
				end else begin
					rr_s[k+1] <= pre;
					rt_s[k+1] <= {rt_s[k][RW-2:0], 1'b0};
				end
				rx_s[k+1] <= rx_s[k]; ry_s[k+1] <= ry_s[k]; rz_s[k+1] <= rz_s[k];
				rg_s[k+1] <= rg_s[k];
			end
		end
	end

	// divide: quotient bit F first, then one bit per stage down to bit 0
	logic [DW-1:0] dd_s [0:F+1];
	logic [DW-1:0] dr_s [0:F+1][3];
	logic [F:0]    dq_s [0:F+1][3];
	sign_t         dg_s [0:F+1];

	assign dd_s[0]    = DW'(rt_s[RW]);
	assign dr_s[0][0] = DW'(rx_s[RW]);
	assign dr_s[0][1] = DW'(ry_s[RW]);
	assign dr_s[0][2] = DW'(rz_s[RW]);
	assign dq_s[0][0] = '0;
	assign dq_s[0][1] = '0;
	assign dq_s[0][2] = '0;
	assign dg_s[0]    = rg_s[RW];

	for (genvar k = 0; k <= F; k++) begin : g_div
		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic [DW-1:0] pr;
			assign pr = (k == 0) ? dr_s[k][c] : {dr_s[k][c][DW-2:0], 1'b0};
			always_ff @(posedge clk) begin
				if (adv) begin
					if (pr >= dd_s[k]) begin
						dr_s[k+1][c] <= pr - dd_s[k];
						dq_s[k+1][c] <= {dq_s[k][c][F-1:0], 1'b1};
					end else begin
						dr_s[k+1][c] <= pr;
						dq_s[k+1][c] <= {dq_s[k][c][F-1:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dd_s[k+1] <= dd_s[k];
				dg_s[k+1] <= dg_s[k];
			end
		end
	end

	// output: apply signs, force zero vector to all zeros
	logic          zero;
	logic [F+1:0]  qx, qy, qz;
	assign zero = (dd_s[F+1] == '0);
	assign qx   = {1'b0, dq_s[F+1][0]};
	assign qy   = {1'b0, dq_s[F+1][1]};
	assign qz   = {1'b0, dq_s[F+1][2]};

	assign res.valid     = vld_s[L-1];
	assign res.is_zero   = zero;
	assign res.magnitude = W'(dd_s[F+1]);
	assign res.x_unit    = zero ? '0 : (dg_s[F+1].x ? -qx : qx);
	assign res.y_unit    = zero ? '0 : (dg_s[F+1].y ? -qy : qy);
	assign res.z_unit    = zero ? '0 : (dg_s[F+1].z ? -qz : qz);

	// an accepted request shows up in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s[0])
		else $error("accepted request missing from first stage");
	// a held result keeps its length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.magnitude))
		else $error("stalled result changed");
	// a reported zero vector has all unit components zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_zero |-> res.x_unit == '0 && res.y_unit == '0
			&& res.z_unit == '0)
		else $error("zero vector with nonzero unit");
endmodule
`default_nettype wire

@@ tb/v3n_checker.sv @@
// Checker for the vector normalization unit: predicts each result from the
// accepted requests and compares it with what the unit returns. Uses v3n_if.sv.
`timescale 1ns / 1ps
module v3n_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	v3n_req_if.sink   req_mon,
	v3n_res_if.sink   res_mon,
	output int        fail_count,
	output int        pending
);
	typedef struct {
		logic signed [31:0] xu;
		logic signed [31:0] yu;
		logic signed [31:0] zu;
		logic        [31:0] mag;
		logic               zero;
	} unit_vec_t;

	unit_vec_t pending_units[$];
	int        checked;

	// floor(sqrt(s)) bit by bit
	function automatic logic [63:0] floor_root(input logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] sq;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t  = r | (64'd1 << i);
			sq = 128'(t) * 128'(t);
			if (sq <= s) r = t;
		end
		return r;
	endfunction

	function automatic unit_vec_t normalize(input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [31:0] z);
		unit_vec_t     u;
		logic [63:0]   a [3];
		logic          n [3];
		logic [127:0]  s;
		logic [63:0]   m;
		logic [127:0]  q;
		logic [31:0]   qs [3];
		a[0] = x[31] ? 64'(-65'(x)) : 64'(x);
		a[1] = y[31] ? 64'(-65'(y)) : 64'(y);
		a[2] = z[31] ? 64'(-65'(z)) : 64'(z);
		n[0] = x[31]; n[1] = y[31]; n[2] = z[31];
		s = 128'(a[0]) * a[0] + 128'(a[1]) * a[1] + 128'(a[2]) * a[2];
		m = floor_root(s);
		if (m == 0) begin
			u.xu = '0; u.yu = '0; u.zu = '0; u.mag = '0; u.zero = 1'b1;
			return u;
		end
		for (int i = 0; i < 3; i++) begin
			q     = (128'(a[i]) << 30) / 128'(m);
			qs[i] = n[i] ? 32'(-q) : 32'(q);
		end
		u.xu = qs[0]; u.yu = qs[1]; u.zu = qs[2];
		u.mag = m[31:0]; u.zero = 1'b0;
		return u;
	endfunction

	task automatic report(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		checked    = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		unit_vec_t e;
		if (arst_n && req_mon.valid && req_mon.ready)
			pending_units.push_back(normalize(req_mon.x_in, req_mon.y_in, req_mon.z_in));
		if (arst_n && res_mon.valid && res_mon.ready) begin
			if (pending_units.size() == 0) begin
				$display("MISMATCH unexpected result %0d", checked);
				fail_count++;
			end else begin
				e = pending_units.pop_front();
				if (res_mon.x_unit !== e.xu) report("x_unit", res_mon.x_unit, e.xu);
				if (res_mon.y_unit !== e.yu) report("y_unit", res_mon.y_unit, e.yu);
				if (res_mon.z_unit !== e.zu) report("z_unit", res_mon.z_unit, e.zu);
				if (res_mon.magnitude !== e.mag) report("magnitude", res_mon.magnitude, e.mag);
				if (res_mon.is_zero !== e.zero)
					report("is_zero", 32'(res_mon.is_zero), 32'(e.zero));
			end
			checked++;
		end
		pending <= pending_units.size();
	end
endmodule

@@ tb/vec3_normalize_unit_tb.sv @@
// Testbench top for vec3_normalize_unit: drives vector requests under varied
// back-pressure and gives the verdict. Depends on v3n_pkg, v3n_if, v3n_checker.
`timescale 1ns / 1ps
module vec3_normalize_unit_tb;
	import v3n_pkg::*;

	localparam int LATENCY   = 32 + 30 + 5;
	localparam int MAX_CYCLE = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle;
	int   send_idle;  // percent of cycles the sender holds off
	int   recv_idle;  // percent of cycles the receiver stalls
	int   sent;

	v3n_req_if #(.W(32)) req ();
	v3n_res_if #(.W(32), .F(30)) res ();

	vec3_normalize_unit #(.IN_WIDTH(32), .OUT_FRAC(30)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source)
	);

	v3n_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req.sink), .res_mon(res.sink),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle counter; ends a hung run
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= MAX_CYCLE) begin
			$display("Timeout after %0d cycles", cycle);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stalls at random
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= recv_idle);
	end

	// pick a component: random, an extreme, zero, a tiny or a mid-range value
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'($signed($urandom_range(8)) - 4);
			3:       return 32'($signed($urandom_range(131072)) - 65536);
			4:       return 32'(0);
			default: return $urandom();
		endcase
	endfunction

	// offer one request, holding it until accepted; idle first at random
	task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.x_in  <= x;
		req.y_in  <= y;
		req.z_in  <= z;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	initial begin
		logic [31:0] ext [4];
		cycle     = 0;
		sent      = 0;
		send_idle = 23;
		recv_idle = 73;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.x_in  = '0;
		req.y_in  = '0;
		req.z_in  = '0;
		res.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, unit axes, smallest nonzero, all extremes
		send_vec(0, 0, 0);
		send_vec(32'h0001_0000, 0, 0);
		send_vec(0, 32'hffff_0000, 0);
		send_vec(0, 0, 32'h0001_0000);
		send_vec(1, 0, 0);
		send_vec(0, 0, 32'hffff_ffff);
		send_vec(1, 1, 1);
		send_vec(32'h8000_0000, 0, 0);
		send_vec(32'h7fff_ffff, 0, 0);
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001};
		for (int i = 0; i < 8; i++)
			send_vec(ext[i[0] ? 0 : 1], ext[i[1] ? 0 : 1], ext[i[2] ? 0 : 1]);
		send_vec(32'h8000_0000, 1, 32'hffff_ffff);
		send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);

		// random: three idle phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
			recv_idle = (ph == 0) ? 73 : (ph == 1) ? 23 : 0;
			for (int n = 0; n < 510; n++)
				send_vec(pick_comp(), pick_comp(), pick_comp());
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Sent %0d vectors: zero, axis, extreme and random components,", sent);
		$display("under sender gaps and receiver stalls in both ratios and at full rate.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/v3n_pkg.sv
rtl/v3n_if.sv
rtl/vec3_normalize_unit.sv
tb/v3n_checker.sv
tb/vec3_normalize_unit_tb.sv
